// ===== rtl/sus_pkg.sv =====
// ----------------------------------------------------------------------------
// sus_pkg
// Types, codes and sizes shared by the sorted unique set block.
// ----------------------------------------------------------------------------
`default_nettype none

package sus_pkg;

  localparam int CAPACITY = 1024;
  localparam int KEY_W    = 64;
  localparam int RANK_W   = 10;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > RANK_W) ? CNT_W : RANK_W;
  localparam int GRP      = 32;
  localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_ERASE  = 2'd1,
    REQ_READ   = 2'd2
  } req_type_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_ERASED   = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4,
    ST_READOK   = 3'd5,
    ST_RANGE    = 3'd6
  } status_e;

  typedef struct packed {
    req_type_e          req_type;
    logic [KEY_W-1:0]   key;
    logic [RANK_W-1:0]  rank;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [KEY_W-1:0]   read_key;
    logic [CNT_W-1:0]   count;
  } rsp_t;

  typedef struct packed {
    logic               cmp;
    logic               rd;
    logic               ins;
    logic               del;
    logic [KEY_W-1:0]   key;
    logic [RANK_W-1:0]  rank;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/sus_cell.sv =====
// ----------------------------------------------------------------------------
// sus_cell
// One slot of the ordered key chain: compares, selects and shifts its key.
// ----------------------------------------------------------------------------
`default_nettype none

module sus_cell (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [sus_pkg::IDX_W-1:0]   idx_i,
  input  wire logic [sus_pkg::CNT_W-1:0]   count_i,
  input  wire sus_pkg::cell_cmd_t          cmd_i,
  input  wire logic [sus_pkg::KEY_W-1:0]   left_key_i,
  input  wire logic                        left_lt_i,
  input  wire logic [sus_pkg::KEY_W-1:0]   right_key_i,
  output logic      [sus_pkg::KEY_W-1:0]   key_o,
  output logic                             lt_o,
  output logic                             hit_o,
  output logic      [sus_pkg::KEY_W-1:0]   sel_o
);

  logic [sus_pkg::KEY_W-1:0] key_q, key_d;
  logic [sus_pkg::KEY_W-1:0] sel_q, sel_d;
  logic                      lt_q, lt_d;
  logic                      eq_q, eq_d;
  logic                      occ;
  logic                      at_rank;

  assign occ     = sus_pkg::CMP_W'(idx_i) < sus_pkg::CMP_W'(count_i);
  assign at_rank = sus_pkg::CMP_W'(idx_i) == sus_pkg::CMP_W'(cmd_i.rank);

  always_comb begin
    lt_d  = lt_q;
    eq_d  = eq_q;
    sel_d = sel_q;
    key_d = key_q;
    if (cmd_i.cmp) begin
      lt_d  = occ && (key_q < cmd_i.key);
      eq_d  = occ && (key_q == cmd_i.key);
      sel_d = (occ && at_rank && cmd_i.rd) ? key_q : '0;
    end
    // insert opens a gap at the first slot not below the key
    if (cmd_i.ins && !lt_q) begin
      key_d = left_lt_i ? cmd_i.key : left_key_i;
    end else if (cmd_i.del && !lt_q) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else begin
      lt_q <= lt_d;
      eq_q <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    sel_q <= sel_d;
  end

  assign key_o = key_q;
  assign lt_o  = lt_q;
  assign hit_o = eq_q;
  assign sel_o = sel_q;

endmodule

`default_nettype wire

// ===== rtl/sus_or_tree.sv =====
// ----------------------------------------------------------------------------
// sus_or_tree
// First registered level of the match and read-data reduction over the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module sus_or_tree (
  input  wire logic                                            clk_i,
  input  wire logic [sus_pkg::CAPACITY-1:0]                    hit_i,
  input  wire logic [sus_pkg::CAPACITY-1:0][sus_pkg::KEY_W-1:0] sel_i,
  output logic      [sus_pkg::NGRP-1:0]                        grp_hit_o,
  output logic      [sus_pkg::NGRP-1:0][sus_pkg::KEY_W-1:0]    grp_sel_o
);

  logic [sus_pkg::NGRP-1:0]                     grp_hit_q, grp_hit_d;
  logic [sus_pkg::NGRP-1:0][sus_pkg::KEY_W-1:0] grp_sel_q, grp_sel_d;

  always_comb begin
    for (int g = 0; g < sus_pkg::NGRP; g++) begin
      grp_hit_d[g] = 1'b0;
      grp_sel_d[g] = '0;
      for (int j = 0; j < sus_pkg::GRP; j++) begin
        if (g * sus_pkg::GRP + j < sus_pkg::CAPACITY) begin
          grp_hit_d[g] = grp_hit_d[g] | hit_i[g * sus_pkg::GRP + j];
          grp_sel_d[g] = grp_sel_d[g] | sel_i[g * sus_pkg::GRP + j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_hit_q <= grp_hit_d;
    grp_sel_q <= grp_sel_d;
  end

  assign grp_hit_o = grp_hit_q;
  assign grp_sel_o = grp_sel_q;

endmodule

`default_nettype wire

// ===== rtl/sorted_unique_set_top.sv =====
// ----------------------------------------------------------------------------
// sorted_unique_set_top
// Ordered set of distinct 64-bit keys held in a chain of compare-and-shift
// cells.
// ----------------------------------------------------------------------------
// Usage: drive req_i and raise start while busy is low; that edge takes the
// request beat (insert, erase or read at rank). busy then stays high until
// the result is decided. Exactly one result beat follows each request: it
// sits on rsp_o for one cycle with done_o high, four clock edges after the
// accepting edge, and must be taken then, as there is no back-pressure.
// Each request runs through these steps: all cells compare the key in
// parallel, the first level of the match and read-data OR tree reduces,
// the reduction is finished, the result decided and the chain shifted,
// then the result beat, during which the next request may already be
// accepted; busy holds off new requests until the reduction is decided.
// Reset clears the count and the sequencer; key slots are not cleared and
// only slots below the count are ever looked at.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_unique_set_top (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start,
  output logic         busy,
  input  wire sus_pkg::req_t req_i,
  output logic         done_o,
  output sus_pkg::rsp_t rsp_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_RED  = 2'd2;
  localparam logic [1:0] S_DEC  = 2'd3;

  logic [1:0]                 state_q, state_d;
  sus_pkg::req_t              req_q;
  logic [sus_pkg::CNT_W-1:0]  count_q, count_d;
  logic                       done_q, done_d;
  sus_pkg::rsp_t              rsp_q, rsp_d;
  sus_pkg::cell_cmd_t         cmd;
  logic                       ins, del;
  logic                       hit;
  logic [sus_pkg::KEY_W-1:0]  rd_key;

  logic [sus_pkg::CAPACITY-1:0]                     cell_lt;
  logic [sus_pkg::CAPACITY-1:0]                     cell_hit;
  logic [sus_pkg::CAPACITY-1:0][sus_pkg::KEY_W-1:0] cell_key;
  logic [sus_pkg::CAPACITY-1:0][sus_pkg::KEY_W-1:0] cell_sel;
  logic [sus_pkg::NGRP-1:0]                         grp_hit;
  logic [sus_pkg::NGRP-1:0][sus_pkg::KEY_W-1:0]     grp_sel;

  assign busy = (state_q != S_IDLE);

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
  end

  always_comb begin
    hit    = 1'b0;
    rd_key = '0;
    for (int g = 0; g < sus_pkg::NGRP; g++) begin
      hit    = hit | grp_hit[g];
      rd_key = rd_key | grp_sel[g];
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    ins     = 1'b0;
    del     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        state_d = S_RED;
      end
      S_RED: begin
        state_d = S_DEC;
      end
      S_DEC: begin
        state_d        = S_IDLE;
        done_d         = 1'b1;
        rsp_d.read_key = '0;
        rsp_d.status   = sus_pkg::ST_RANGE;
        case (req_q.req_type)
          sus_pkg::REQ_INSERT: begin
            if (hit) begin
              rsp_d.status = sus_pkg::ST_PRESENT;
            end else if (count_q == sus_pkg::CNT_W'(sus_pkg::CAPACITY)) begin
              rsp_d.status = sus_pkg::ST_FULL;
            end else begin
              rsp_d.status = sus_pkg::ST_INSERTED;
              ins          = 1'b1;
              count_d      = count_q + 1'b1;
            end
          end
          sus_pkg::REQ_ERASE: begin
            if (hit) begin
              rsp_d.status = sus_pkg::ST_ERASED;
              del          = 1'b1;
              count_d      = count_q - 1'b1;
            end else begin
              rsp_d.status = sus_pkg::ST_NOTFOUND;
            end
          end
          sus_pkg::REQ_READ: begin
            if (sus_pkg::CMP_W'(req_q.rank) < sus_pkg::CMP_W'(count_q)) begin
              rsp_d.status   = sus_pkg::ST_READOK;
              rsp_d.read_key = rd_key;
            end
          end
          default: begin
            rsp_d.status = sus_pkg::ST_RANGE;
          end
        endcase
        rsp_d.count = count_d;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign cmd.cmp  = (state_q == S_CMP);
  assign cmd.rd   = (req_q.req_type == sus_pkg::REQ_READ);
  assign cmd.ins  = ins;
  assign cmd.del  = del;
  assign cmd.key  = req_q.key;
  assign cmd.rank = req_q.rank;

  for (genvar i = 0; i < sus_pkg::CAPACITY; i++) begin : g_cell
    logic [sus_pkg::KEY_W-1:0] left_key;
    logic                      left_lt;
    logic [sus_pkg::KEY_W-1:0] right_key;

    if (i == 0) begin : g_first
      assign left_key = '0;
      assign left_lt  = 1'b1;
    end else begin : g_mid
      assign left_key = cell_key[i-1];
      assign left_lt  = cell_lt[i-1];
    end

    if (i == sus_pkg::CAPACITY - 1) begin : g_last
      assign right_key = '0;
    end else begin : g_inner
      assign right_key = cell_key[i+1];
    end

    sus_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .idx_i       (sus_pkg::IDX_W'(i)),
      .count_i     (count_q),
      .cmd_i       (cmd),
      .left_key_i  (left_key),
      .left_lt_i   (left_lt),
      .right_key_i (right_key),
      .key_o       (cell_key[i]),
      .lt_o        (cell_lt[i]),
      .hit_o       (cell_hit[i]),
      .sel_o       (cell_sel[i])
    );
  end

  sus_or_tree u_tree (
    .clk_i     (clk_i),
    .hit_i     (cell_hit),
    .sel_i     (cell_sel),
    .grp_hit_o (grp_hit),
    .grp_sel_o (grp_sel)
  );

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/sus_checker.sv =====
// ----------------------------------------------------------------------------
// sus_checker
// Port-level checks on request and result timing, count bounds and result fields of the sorted unique set.
// ----------------------------------------------------------------------------
`default_nettype none

module sus_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          done_o,
  input wire sus_pkg::rsp_t rsp_o
);

  // each result beat must match an earlier accepted request beat
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 4))
    else $error("result beat without matching request beat");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after request beat");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.count <= sus_pkg::CNT_W'(sus_pkg::CAPACITY)))
    else $error("count beyond capacity");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status == sus_pkg::ST_FULL))
      |-> (rsp_o.count == sus_pkg::CNT_W'(sus_pkg::CAPACITY)))
    else $error("full reported below capacity");

  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status != sus_pkg::ST_READOK)) |-> (rsp_o.read_key == '0))
    else $error("read key not zero on non-read result");

endmodule

bind sorted_unique_set_top sus_checker u_sus_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

`default_nettype wire

// ===== tb/sorted_unique_set_top_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_unique_set_top_tb
// Self-checking bench for the ordered set of distinct 64-bit keys. A short
// table of directed requests opens the run, then random requests fill the
// set to capacity, exercise it while full and drain part of it again, with
// several sender gap profiles. A model of the set in the bench or a typed
// directed row gives each response beat, compared field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_unique_set_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sus_pkg::*;

  localparam req_type_e REQ_NOOP = req_type_e'(2'd3);
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic done_o;
  rsp_t rsp_o;

  logic [KEY_W-1:0] held_keys[$];
  rsp_t             pending_rsp[$];
  dir_row_t         dir_rows[$];

  int mismatches = 0;
  int requests_sent = 0;
  int responses_seen = 0;
  int peak_count = 0;
  int status_seen[8];
  int stall_cycles = 0;

  sorted_unique_set_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // updates the model of the set and returns the response it calls for
  function automatic rsp_t apply_to_set(req_t r);
    rsp_t res;
    int   pos;
    bit   hit;
    res = '{status: ST_RANGE, read_key: '0, count: '0};
    pos = 0;
    while (pos < held_keys.size() && held_keys[pos] < r.key) pos++;
    hit = (pos < held_keys.size()) && (held_keys[pos] == r.key);
    case (r.req_type)
      REQ_INSERT: begin
        if (hit) begin
          res.status = ST_PRESENT;
        end else if (held_keys.size() >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          held_keys.insert(pos, r.key);
          res.status = ST_INSERTED;
        end
      end
      REQ_ERASE: begin
        if (hit) begin
          held_keys.delete(pos);
          res.status = ST_ERASED;
        end else begin
          res.status = ST_NOTFOUND;
        end
      end
      REQ_READ: begin
        if (int'(r.rank) < held_keys.size()) begin
          res.status   = ST_READOK;
          res.read_key = held_keys[r.rank];
        end
      end
      default: res.status = ST_RANGE;
    endcase
    res.count = CNT_W'(held_keys.size());
    if (held_keys.size() > peak_count) peak_count = held_keys.size();
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(int fresh_pct);
    logic [KEY_W-1:0] base;
    if (held_keys.size() == 0 || $urandom_range(99) < fresh_pct) begin
      if ($urandom_range(15) == 0) return $urandom_range(1) ? '1 : '0;
      return {$urandom, $urandom};
    end
    base = held_keys[$urandom_range(held_keys.size() - 1)];
    case ($urandom_range(3))
      0: return base + 1'b1;
      1: return base - 1'b1;
      default: return base;
    endcase
  endfunction

  function automatic req_t make_req(int ins_pct, int era_pct, int rd_pct, int fresh_pct);
    req_t        r;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < ins_pct) r.req_type = REQ_INSERT;
    else if (roll < ins_pct + era_pct) r.req_type = REQ_ERASE;
    else if (roll < ins_pct + era_pct + rd_pct) r.req_type = REQ_READ;
    else r.req_type = REQ_NOOP;
    r.key = pick_key(fresh_pct);
    case ($urandom_range(3))
      0: r.rank = RANK_W'($urandom);
      1: r.rank = RANK_W'(held_keys.size());
      default: begin
        if (held_keys.size() > 0) r.rank = RANK_W'($urandom_range(held_keys.size() - 1));
        else r.rank = RANK_W'($urandom);
      end
    endcase
    return r;
  endfunction

  // one request beat: hold start until the block takes it
  task automatic send_req(req_t r, bit typed, rsp_t typed_rsp);
    rsp_t predicted;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    predicted = apply_to_set(r);
    pending_rsp.push_back(typed ? typed_rsp : predicted);
    requests_sent++;
  endtask

  task automatic sender_gap(int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic settle;
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(int n_items, int idle_pct, int ins_pct, int era_pct,
                           int rd_pct, int fresh_pct, bit stop_when_full);
    for (int i = 0; i < n_items; i++) begin
      if (stop_when_full && held_keys.size() >= CAPACITY) break;
      sender_gap(idle_pct);
      send_req(make_req(ins_pct, era_pct, rd_pct, fresh_pct), 1'b0, '0);
    end
    settle();
  endtask

  task automatic add_row(req_type_e t, logic [KEY_W-1:0] k, logic [RANK_W-1:0] rk,
                         bit typed, status_e st, logic [KEY_W-1:0] rd, int cnt);
    dir_row_t row;
    row.req   = '{req_type: t, key: k, rank: rk};
    row.typed = typed;
    row.want  = '{status: st, read_key: rd, count: CNT_W'(cnt)};
    dir_rows.push_back(row);
  endtask

  task automatic note_fault(string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t mismatch: %s", $realtime, what);
  endtask

  always @(posedge clk_i) begin : check_results
    rsp_t want;
    if (rst_ni && done_o) begin
      responses_seen++;
      status_seen[rsp_o.status]++;
      if (pending_rsp.size() == 0) begin
        note_fault($sformatf("response beat with nothing pending: status %0d key %h count %0d",
                             rsp_o.status, rsp_o.read_key, rsp_o.count));
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_o.status !== want.status || rsp_o.read_key !== want.read_key ||
            rsp_o.count !== want.count) begin
          note_fault($sformatf("want status %0d key %h count %0d, got status %0d key %h count %0d",
                               want.status, want.read_key, want.count,
                               rsp_o.status, rsp_o.read_key, rsp_o.count));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d responses pending",
               stall_cycles, pending_rsp.size());
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    foreach (status_seen[s]) status_seen[s] = 0;

    add_row(REQ_READ,   '0,         '0,  1, ST_RANGE,    '0, 0);
    add_row(REQ_ERASE,  64'd5,      '0,  1, ST_NOTFOUND, '0, 0);
    add_row(REQ_NOOP,   '1,         '1,  1, ST_RANGE,    '0, 0);
    add_row(REQ_INSERT, '0,         '1,  1, ST_INSERTED, '0, 1);
    add_row(REQ_INSERT, '1,         '0,  1, ST_INSERTED, '0, 2);
    add_row(REQ_INSERT, '0,         '0,  1, ST_PRESENT,  '0, 2);
    add_row(REQ_INSERT, '1,         '1,  1, ST_PRESENT,  '0, 2);
    add_row(REQ_READ,   '1,         10'd0, 1, ST_READOK, '0, 2);
    add_row(REQ_READ,   '0,         10'd1, 1, ST_READOK, '1, 2);
    add_row(REQ_READ,   '0,         10'd2, 1, ST_RANGE,  '0, 2);
    add_row(REQ_READ,   '0,         '1,  1, ST_RANGE,    '0, 2);
    add_row(REQ_INSERT, 64'h8000_0000_0000_0000, '1, 1, ST_INSERTED, '0, 3);
    add_row(REQ_INSERT, 64'h7fff_ffff_ffff_ffff, '0, 1, ST_INSERTED, '0, 4);
    add_row(REQ_INSERT, 64'h5555_5555_5555_5555, '0, 0, ST_RANGE, '0, 0);
    add_row(REQ_INSERT, 64'haaaa_aaaa_aaaa_aaaa, '1, 0, ST_RANGE, '0, 0);
    add_row(REQ_READ,   '1,         10'd2, 0, ST_RANGE,  '0, 0);
    add_row(REQ_READ,   '0,         10'd3, 0, ST_RANGE,  '0, 0);
    add_row(REQ_ERASE,  64'h8000_0000_0000_0000, '0, 1, ST_ERASED, '0, 5);
    add_row(REQ_ERASE,  64'h8000_0000_0000_0000, '1, 1, ST_NOTFOUND, '0, 5);
    add_row(REQ_ERASE,  '0,         '0,  1, ST_ERASED,   '0, 4);
    add_row(REQ_READ,   '0,         10'd0, 0, ST_RANGE,  '0, 0);
    add_row(REQ_NOOP,   '0,         10'd0, 1, ST_RANGE,  '0, 4);
    add_row(REQ_ERASE,  '1,         '1,  1, ST_ERASED,   '0, 3);
    add_row(REQ_READ,   '0,         10'd3, 1, ST_RANGE,  '0, 3);
    add_row(REQ_INSERT, 64'd1,      '1,  0, ST_RANGE,    '0, 0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    settle();

    // mixed traffic, back to back beats
    run_phase(150, 0, 45, 25, 25, 40, 1'b0);
    // fill to capacity with a mostly idle sender
    run_phase(1600, 73, 85, 3, 10, 90, 1'b1);
    // while full: present keys, full refusals, reads
    run_phase(60, 0, 70, 0, 25, 40, 1'b0);
    // partial drain with light gaps
    run_phase(200, 10, 20, 60, 15, 10, 1'b0);

    repeat (8) @(posedge clk_i);

    $display("%0d requests, %0d responses checked, peak occupancy %0d of %0d",
             requests_sent, responses_seen, peak_count, CAPACITY);
    $display("inserted %0d, present %0d, erased %0d, not found %0d, full %0d, read %0d, range %0d",
             status_seen[ST_INSERTED], status_seen[ST_PRESENT], status_seen[ST_ERASED],
             status_seen[ST_NOTFOUND], status_seen[ST_FULL], status_seen[ST_READOK],
             status_seen[ST_RANGE]);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d responses missing", mismatches, pending_rsp.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/sus_pkg.sv
rtl/sus_cell.sv
rtl/sus_or_tree.sv
rtl/sorted_unique_set_top.sv
rtl/sus_checker.sv
tb/sorted_unique_set_top_tb.sv
